>>> rtl/core/tms_pkg.sv
package tms_pkg;

  localparam int GRID_W = 1024;
  localparam int GRID_H = 1024;
  localparam int CELL_COUNT = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int POS_W = 12;
  localparam int VISIT_W = 32;
  localparam int COLOUR_W = 4;
  localparam int MAX_COLOURS = 16;

  localparam logic [0:0] REG_COLOUR_COUNT = 1'b0;
  localparam logic [0:0] REG_TURN_MASK = 1'b1;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW
  } state_t;

  typedef struct packed {
    logic [VISIT_W-1:0] visits;
    logic [COLOUR_W-1:0] colour;
  } cell_t;

  typedef struct packed {
    cell_t next_cell;
    logic [1:0] dir;
  } rule_res_t;

  function automatic logic inside_grid(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    inside_grid = (x != '0) && (x < POS_W'(GRID_W)) && (y != '0) && (y < POS_W'(GRID_H));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y);
    logic [2*POS_W-1:0] lin;
    lin = (2*POS_W)'(y) * (2*POS_W)'(GRID_W) + (2*POS_W)'(x);
    cell_addr = lin[ADDR_W-1:0];
  endfunction

endpackage

>>> rtl/core/multicolour_turmite_step_top.sv
// Channel  Direction  Handshake                Payload
// in       slave      in_tvalid / in_tready    in_tuser: op; in_tdata: read_x, read_y
// out      master     out_tvalid / out_tready  out_tdata: ant position, heading, cell, peak
// cfg      slave      cfg_valid / cfg_ready    cfg_index, cfg_data
// An item reads its cell from the grid RAM and then updates the cell and writes it back;
// the next step needs the cell just written, so items never overlap.
// After reset the block clears the grid RAM, one cell per cycle, all GRID_W * GRID_H cells
// (1048576 at the default size), before it accepts the first item.
// A new item is accepted while the previous result waits in the output register;
// the write-back cycle stalls until that register is free.
module multicolour_turmite_step_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // read_x [9:0], read_y [19:10], zero fill
  input  logic [0:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // ant_x [10:0], ant_y [21:11], heading [23:22], halted [24],
  // cell_colour [28:25], cell_visits [60:29], max_visits [92:61], zero fill
  output logic [95:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tms_pkg::*;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  clr_addr_r;
  logic               op_r;
  logic               rd_ok_r;
  logic [POS_W-1:0]   pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]   pos_y_r, pos_y_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [VISIT_W-1:0] peak_r, peak_nxt;
  logic [4:0]         colour_count_r;
  logic [15:0]        turn_mask_r;
  logic               out_valid_r;
  logic [95:0]        out_data_r;

  logic               in_fire;
  logic               rmw_fire;
  logic               clear_done;
  logic               step_ok;
  logic               do_step;
  logic [POS_W-1:0]   rd_x;
  logic [POS_W-1:0]   rd_y;
  logic               rd_ok;
  logic [ADDR_W-1:0]  step_addr;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  cell_t              ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [$bits(cell_t)-1:0] ram_rdata;
  cell_t              cell_rd;
  rule_res_t          rule;
  cell_t              cell_out;
  logic               halted_nxt;

  assign rd_x = POS_W'(in_tdata[9:0]);
  assign rd_y = POS_W'(in_tdata[19:10]);
  assign rd_ok = (rd_x < POS_W'(GRID_W)) && (rd_y < POS_W'(GRID_H));
  assign step_ok = inside_grid(pos_x_r, pos_y_r);
  assign step_addr = cell_addr(pos_x_r, pos_y_r);
  assign in_fire = in_tvalid && in_tready;
  assign rmw_fire = (state_r == ST_RMW) && (!out_valid_r || out_tready);
  assign clear_done = (clr_addr_r == ADDR_W'(CELL_COUNT - 1));
  assign do_step = rmw_fire && !op_r && step_ok;
  assign cell_rd = cell_t'(ram_rdata);

  tms_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tms_rule u_rule (
    .cell_in         (cell_rd),
    .colour_count    (colour_count_r),
    .turn_right_mask (turn_mask_r),
    .dir_in          (dir_r),
    .res             (rule)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (rmw_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ram_we = 1'b0;
    ram_waddr = step_addr;
    ram_wdata = rule.next_cell;
    ram_re = 1'b0;
    ram_raddr = in_tuser[0] ? cell_addr(rd_x, rd_y) : step_addr;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_re = in_tvalid;
      end
      ST_RMW: begin
        ram_we = do_step;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    dir_nxt = dir_r;
    peak_nxt = peak_r;
    if (do_step) begin
      dir_nxt = rule.dir;
      if (rule.next_cell.visits > peak_r) begin
        peak_nxt = rule.next_cell.visits;
      end
      case (rule.dir)
        DIR_NORTH: pos_y_nxt = pos_y_r - POS_W'(1);
        DIR_EAST:  pos_x_nxt = pos_x_r + POS_W'(1);
        DIR_SOUTH: pos_y_nxt = pos_y_r + POS_W'(1);
        default:   pos_x_nxt = pos_x_r - POS_W'(1);
      endcase
    end
    halted_nxt = !inside_grid(pos_x_nxt, pos_y_nxt);
    cell_out = (op_r && rd_ok_r) ? cell_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_addr_r <= '0;
      pos_x_r <= POS_W'(GRID_W / 2);
      pos_y_r <= POS_W'(GRID_H / 2);
      dir_r <= DIR_NORTH;
      peak_r <= VISIT_W'(1);
      colour_count_r <= 5'd3;
      turn_mask_r <= 16'd5;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      dir_r <= dir_nxt;
      peak_r <= peak_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_COLOUR_COUNT: colour_count_r <= cfg_data[4:0];
          REG_TURN_MASK:    turn_mask_r <= cfg_data;
          default:          turn_mask_r <= turn_mask_r;
        endcase
      end
      if (rmw_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_tuser[0];
      rd_ok_r <= rd_ok;
    end
    if (rmw_fire) begin
      out_data_r <= {3'b000, peak_nxt, cell_out.visits, cell_out.colour, halted_nxt,
                     dir_nxt, pos_y_nxt[10:0], pos_x_nxt[10:0]};
    end
  end

  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

endmodule

>>> rtl/core/tms_ram.sv
module tms_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/tms_rule.sv
module tms_rule (
  input  tms_pkg::cell_t     cell_in,
  input  logic [4:0]         colour_count,
  input  logic [15:0]        turn_right_mask,
  input  logic [1:0]         dir_in,
  output tms_pkg::rule_res_t res
);
  import tms_pkg::*;

  logic [4:0] limit;
  logic [4:0] colour_inc;
  logic       turn_right;

  always_comb begin
    limit = (colour_count > 5'(MAX_COLOURS)) ? 5'(MAX_COLOURS) : colour_count;
    colour_inc = 5'(cell_in.colour) + 5'd1;
    turn_right = turn_right_mask[cell_in.colour];
    res.dir = turn_right ? dir_in + 2'd1 : dir_in - 2'd1;
    res.next_cell.colour = (colour_inc >= limit) ? '0 : colour_inc[COLOUR_W-1:0];
    res.next_cell.visits = (&cell_in.visits) ? cell_in.visits : cell_in.visits + VISIT_W'(1);
  end

endmodule
